>>> hdl/dstm_pkg.sv
// ============================================================================
// dstm_pkg
// Shared types and constants of the drum sample trigger mixer: command and
// status bundles between controller and datapath, state encoding, codes.
// ============================================================================
package dstm_pkg;

   // defaults for the top-level parameters
   localparam int DEF_TRACKS       = 6;
   localparam int DEF_SAMPLE_DEPTH = 16384;

   // fixed field widths
   localparam int BUTTON_BITS = 6;
   localparam int TRK_FIELD_W = 3;
   localparam int IDX_FIELD_W = 14;
   localparam int SAMPLE_W    = 16;
   localparam int HOLD_W      = 16;
   localparam int LEN_W       = 15;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int DAC_W       = 16;

   // tracks that own a length register
   localparam int LEN_REGS = 6;

   // reset value of the debounce threshold
   localparam logic [HOLD_W-1:0] STABLE_RESET = 16'd661;
   localparam logic [HOLD_W-1:0] HOLD_MAX     = 16'hFFFF;

   // mix limits and DAC offset
   localparam int MIX_MIN    = -32768;
   localparam int MIX_MAX    = 32767;
   localparam int DAC_OFFSET = 32768;

   // request command codes
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_STABLE_TICKS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LENGTH_TRACK0 = 3'd1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } dstm_state_type;

   // controller -> datapath
   typedef struct packed {
      logic tick_start;   // tick request taken: debounce update, clear mix
      logic load_write;   // load request taken: write sample memory
      logic scan_step;    // visit the track under the cursor
      logic out_load;     // move the clamped mix into the response register
   } dstm_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic scan_last;    // cursor on the last track
      logic out_full;     // response register holds a result
   } dstm_status_type;

endpackage

>>> hdl/dstm_ctrl.sv
// ============================================================================
// dstm_ctrl
// Sequencer: takes requests, steps the track scan, drains the read pipe and
// hands the mix to the response register.
// ============================================================================
module dstm_ctrl
   import dstm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_command,
   output logic            req_stall,
   input  logic            rsp_stall,
   input  dstm_status_type status,
   output dstm_cmd_type    cmd
);

   dstm_state_type state_ff, state_in;

   logic slot_free;
   logic take;
   logic accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      slot_free = !status.out_full || !rsp_stall;
      take      = (state_ff == ST_IDLE) || ((state_ff == ST_FINISH) && slot_free);
      req_stall = !take;
      accept    = req_valid && take;

      cmd            = '0;
      cmd.tick_start = accept && (req_command == CMD_TICK);
      cmd.load_write = accept && (req_command == CMD_LOAD);
      state_in       = state_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.tick_start) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               state_in     = cmd.tick_start ? ST_SCAN : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && status.scan_last |=> (state_ff == ST_DRAIN))
      else $error("scan did not hand over to drain");

endmodule

>>> hdl/dstm_datapath.sv
// ============================================================================
// dstm_datapath
// Settings, per-track debounce and playback state, sample memory, mix
// accumulator, clamp and response register.
// ============================================================================
module dstm_datapath
   import dstm_pkg::*;
#(
   parameter int TRACKS       = DEF_TRACKS,
   parameter int SAMPLE_DEPTH = DEF_SAMPLE_DEPTH
)
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data,
   input  logic [BUTTON_BITS-1:0]        req_buttons,
   input  logic [TRK_FIELD_W-1:0]        req_load_track,
   input  logic [IDX_FIELD_W-1:0]        req_load_index,
   input  logic signed [SAMPLE_W-1:0]    req_load_value,
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [DAC_W-1:0]              rsp_dac_value,
   input  dstm_cmd_type                  cmd,
   output dstm_status_type               status
);

   localparam int MEM_DEPTH = TRACKS * SAMPLE_DEPTH;
   localparam int ADDR_W    = $clog2(MEM_DEPTH);
   localparam int CUR_W     = (TRACKS > 1) ? $clog2(TRACKS) : 1;
   localparam int SUM_W     = SAMPLE_W + 1 + $clog2(TRACKS);
   localparam int BTN_W     = (TRACKS > BUTTON_BITS) ? TRACKS : BUTTON_BITS;
   localparam int LEN_CAP   = (SAMPLE_DEPTH > 32767) ? 32767 : SAMPLE_DEPTH;
   localparam logic [LEN_W-1:0]  LEN_CAP_V = LEN_W'(LEN_CAP);
   localparam logic [16:0]       DEPTH_V   = 17'(SAMPLE_DEPTH);
   localparam logic [4:0]        TRACKS_V  = 5'(TRACKS);
   localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(MIX_MIN);
   localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(MIX_MAX);
   localparam logic signed [SUM_W-1:0] SUM_OFS = SUM_W'(DAC_OFFSET);

   // settings
   logic [HOLD_W-1:0] stable_ff, stable_in;
   logic [LEN_W-1:0]  len_ff [TRACKS];
   logic [LEN_W-1:0]  len_in [TRACKS];

   // per-track state
   logic [HOLD_W-1:0] hold_ff [TRACKS];
   logic [HOLD_W-1:0] hold_in [TRACKS];
   logic [LEN_W-1:0]  rem_ff  [TRACKS];
   logic [LEN_W-1:0]  rem_in  [TRACKS];
   logic [TRACKS-1:0] playing_ff, playing_in;

   // scan and mix
   logic [CUR_W-1:0]         cursor_ff, cursor_in;
   logic                     rd_valid_ff;
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DAC_W-1:0]         dac_ff;
   logic [DAC_W-1:0]         dac_in;

   logic signed [SAMPLE_W-1:0] sample_mem_ff [MEM_DEPTH];

   logic [BTN_W-1:0]  pressed;
   logic [LEN_W-1:0]  cur_len;
   logic [LEN_W-1:0]  cur_rem;
   logic [LEN_W-1:0]  cur_pos;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;

   function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] n);
      return (n > LEN_CAP_V) ? LEN_CAP_V : n;
   endfunction

   // configuration writes
   always_comb begin
      stable_in = stable_ff;
      if (csr_write && (csr_index == REG_STABLE_TICKS)) begin
         stable_in = csr_data;
      end
      for (int t = 0; t < TRACKS; t++) begin
         len_in[t] = len_ff[t];
         if ((t < LEN_REGS) && csr_write &&
             (csr_index == CSR_IDX_W'(int'(REG_LENGTH_TRACK0) + t))) begin
            len_in[t] = csr_data[LEN_W-1:0];
         end
      end
   end

   // debounce on a tick, then one track per scan step
   always_comb begin
      pressed = BTN_W'(~req_buttons);
      cur_len = eff_len(len_ff[cursor_ff]);
      cur_rem = rem_ff[cursor_ff];
      cur_pos = (cur_rem <= cur_len) ? (cur_len - cur_rem) : '0;
      rd_en   = cmd.scan_step && playing_ff[cursor_ff] && (cur_rem != '0);
      rd_addr = ADDR_W'(cursor_ff) * ADDR_W'(SAMPLE_DEPTH) + ADDR_W'(cur_pos);

      playing_in = playing_ff;
      for (int t = 0; t < TRACKS; t++) begin
         hold_in[t] = hold_ff[t];
         rem_in[t]  = rem_ff[t];
      end

      if (cmd.tick_start) begin
         for (int t = 0; t < TRACKS; t++) begin
            if (pressed[t]) begin
               if ((hold_ff[t] == stable_ff) && (eff_len(len_ff[t]) != '0)) begin
                  rem_in[t]     = eff_len(len_ff[t]);
                  playing_in[t] = 1'b1;
               end
               if (hold_ff[t] != HOLD_MAX) begin
                  hold_in[t] = hold_ff[t] + 1'b1;
               end
            end else begin
               hold_in[t] = '0;
            end
         end
      end else if (cmd.scan_step && playing_ff[cursor_ff]) begin
         if (cur_rem == '0) begin
            playing_in[cursor_ff] = 1'b0;
         end else begin
            rem_in[cursor_ff] = cur_rem - 1'b1;
            if (cur_rem == LEN_W'(1)) begin
               playing_in[cursor_ff] = 1'b0;
            end
         end
      end

      cursor_in = cursor_ff;
      if (cmd.tick_start) begin
         cursor_in = '0;
      end else if (cmd.scan_step && !status.scan_last) begin
         cursor_in = cursor_ff + 1'b1;
      end
   end

   // mix, clamp, response register
   always_comb begin
      sum_in = sum_ff;
      if (cmd.tick_start) begin
         sum_in = '0;
      end else if (rd_valid_ff) begin
         sum_in = sum_ff + SUM_W'(rd_data_ff);
      end

      priority if (sum_ff < SUM_MIN) begin
         dac_in = '0;
      end else if (sum_ff > SUM_MAX) begin
         dac_in = '1;
      end else begin
         dac_in = DAC_W'(sum_ff + SUM_OFS);
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      wr_en   = cmd.load_write && ({2'b00, req_load_track} < TRACKS_V) &&
                (17'(req_load_index) < DEPTH_V);
      wr_addr = ADDR_W'(req_load_track) * ADDR_W'(SAMPLE_DEPTH) + ADDR_W'(req_load_index);

      status.scan_last = (cursor_ff == CUR_W'(TRACKS - 1));
      status.out_full  = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff    <= STABLE_RESET;
         playing_ff   <= '0;
         cursor_ff    <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int t = 0; t < TRACKS; t++) begin
            len_ff[t]  <= '0;
            hold_ff[t] <= '0;
            rem_ff[t]  <= '0;
         end
      end else begin
         stable_ff    <= stable_in;
         playing_ff   <= playing_in;
         cursor_ff    <= cursor_in;
         rd_valid_ff  <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
         for (int t = 0; t < TRACKS; t++) begin
            len_ff[t]  <= len_in[t];
            hold_ff[t] <= hold_in[t];
            rem_ff[t]  <= rem_in[t];
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (cmd.out_load) begin
         dac_ff <= dac_in;
      end
   end

   // sample memory: one write port for loads, one registered read port for the scan
   always_ff @(posedge clock) begin
      if (wr_en) begin
         sample_mem_ff[wr_addr] <= req_load_value;
      end
      if (rd_en) begin
         rd_data_ff <= sample_mem_ff[rd_addr];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_dac_value = dac_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response register loaded while a result still waits");

   a_mix_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.tick_start |=> (sum_ff == '0))
      else $error("mix not cleared at tick start");

   a_playing_has_samples: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step && playing_ff[cursor_ff] |-> (rem_ff[cursor_ff] != '0))
      else $error("track playing with no samples left");

endmodule

>>> hdl/drum_sample_trigger_mixer_unit.sv
// ============================================================================
// drum_sample_trigger_mixer_unit
// Six-track one-shot drum sample player with debounced triggers and a
// clamped, offset mix for the DAC.
// ============================================================================
// Response: a tick request gives its DAC value once the scan of all tracks,
//   the drain and the finish are through; a load request gives no response.
// Throughput: ticks do not overlap, a new tick is taken at finish at the
//   earliest, as the scan visits one track per cycle through the single read
//   port of the sample memory; loads: one per cycle while no tick is being mixed.
// Reset: sequencer, debounce counters and playback state clear, threshold
//   returns to 661, track lengths to zero; the sample memory is not cleared.
module drum_sample_trigger_mixer_unit
   import dstm_pkg::*;
#(
   parameter int TRACKS       = DEF_TRACKS,
   parameter int SAMPLE_DEPTH = DEF_SAMPLE_DEPTH
)
(
   input  logic                       clock,
   input  logic                       reset,
   // configuration
   input  logic                       csr_write,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_command,
   input  logic [BUTTON_BITS-1:0]     req_buttons,
   input  logic [TRK_FIELD_W-1:0]     req_load_track,
   input  logic [IDX_FIELD_W-1:0]     req_load_index,
   input  logic signed [SAMPLE_W-1:0] req_load_value,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [DAC_W-1:0]           rsp_dac_value
);

   // Flow of a tick request:
   //   accept edge  - all debounce counters step at once; a counter equal to the
   //                  threshold (re)starts its track from the first sample
   //   scan         - one track per cycle: position = length - remaining,
   //                  memory read issued, remaining decremented
   //   drain        - the last read data lands in the accumulator
   //   finish       - clamp to signed 16 bits, add 32768, load the response
   //                  register; the next request may be taken in this cycle
   // The response register decouples the two channels: a waiting result only
   // holds the sequencer at finish, loads are still taken while idle.

   dstm_cmd_type    cmd;
   dstm_status_type status;

   dstm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   dstm_datapath #(
      .TRACKS       (TRACKS),
      .SAMPLE_DEPTH (SAMPLE_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_buttons    (req_buttons),
      .req_load_track (req_load_track),
      .req_load_index (req_load_index),
      .req_load_value (req_load_value),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_dac_value  (rsp_dac_value),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

>>> tb/tb_drum_sample_trigger_mixer_unit.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_drum_sample_trigger_mixer_unit
// Self-checking bench for the drum sample trigger mixer. A scripted part
// covers reset values, mix clamping, out-of-range loads and the length
// corner cases. Random phases follow, each with its own threshold and
// lengths. A final short hold runs against the threshold at its top.
// Every tick request is predicted by a local copy of the debounce, playback
// and mix logic, and each DAC value is checked in order.
// ============================================================================
module tb_drum_sample_trigger_mixer_unit;
   import dstm_pkg::*;

   localparam int TRACKS          = DEF_TRACKS;
   localparam int SAMPLE_DEPTH    = DEF_SAMPLE_DEPTH;
   localparam int PRELOAD_DEPTH   = 32;          // written prefix of every track
   localparam int SETTLE_CYCLES   = TRACKS + 4;  // covers a load still in flight
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_ITEMS     = 50;
   localparam int TOP_HOLD_TICKS  = 16;          // held ticks at the top threshold

   localparam logic [CSR_IDX_W-1:0]   REG_OUT_OF_LIST = 3'd7;
   localparam logic [BUTTON_BITS-1:0] ALL_RELEASED    = 6'b111111;
   localparam logic [BUTTON_BITS-1:0] ALL_PRESSED     = 6'b000000;
   localparam logic [BUTTON_BITS-1:0] TRACK0_PRESSED  = 6'b111110;
   localparam logic [SAMPLE_W-1:0]    SAMPLE_MAX      = 16'h7FFF;
   localparam logic [SAMPLE_W-1:0]    SAMPLE_MIN      = 16'h8000;
   localparam logic [DAC_W-1:0]       DAC_MID         = 16'h8000;
   localparam logic [DAC_W-1:0]       DAC_TOP         = 16'hFFFF;
   localparam logic [DAC_W-1:0]       DAC_BOTTOM      = 16'h0000;

   typedef enum logic [1:0] {
      ROW_TICK,
      ROW_LOAD,
      ROW_REG
   } row_kind_type;

   // one scripted step; sel is the load track or the register index
   typedef struct packed {
      row_kind_type             kind;
      logic [BUTTON_BITS-1:0]   buttons;
      logic [CSR_IDX_W-1:0]     sel;
      logic [IDX_FIELD_W-1:0]   index;
      logic [SAMPLE_W-1:0]      value;
      logic                     typed;
      logic [DAC_W-1:0]         dac;
   } script_row_type;

   // --------------------------------------------------------------------------
   // DUT inputs, all known from time zero
   // --------------------------------------------------------------------------
   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       csr_write      = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index      = '0;
   logic [CSR_DATA_W-1:0]      csr_data       = '0;
   logic                       req_valid      = 1'b0;
   logic                       req_stall;
   logic                       req_command    = CMD_TICK;
   logic [BUTTON_BITS-1:0]     req_buttons    = ALL_RELEASED;
   logic [TRK_FIELD_W-1:0]     req_load_track = '0;
   logic [IDX_FIELD_W-1:0]     req_load_index = '0;
   logic signed [SAMPLE_W-1:0] req_load_value = '0;
   logic                       rsp_valid;
   logic                       rsp_stall      = 1'b0;
   logic [DAC_W-1:0]           rsp_dac_value;

   // expected value typed into the script, travels with the request
   logic                       typed_dac_en   = 1'b0;
   logic [DAC_W-1:0]           typed_dac      = '0;

   // --------------------------------------------------------------------------
   // Bench state
   // --------------------------------------------------------------------------
   logic [DAC_W-1:0]   dac_expect_q [$];
   script_row_type     script_q [$];
   int                 error_count = 0;
   int                 idle_cycles = 0;
   int                 burst_left  = 0;
   bit                 quiet       = 1'b0;   // no gaps, no stalls
   int                 stall_left  = 0;
   int                 stall_mode  = 0;

   // shadow of the block: registers, debounce, playback, sample memory
   logic [HOLD_W-1:0]  thresh;
   logic [LEN_W-1:0]   track_len [TRACKS];
   logic [HOLD_W-1:0]  hold_cnt  [TRACKS];
   int                 remain    [TRACKS];
   bit                 active    [TRACKS];
   logic [SAMPLE_W-1:0] sample_mem  [TRACKS*SAMPLE_DEPTH];
   bit                  sample_seen [TRACKS*SAMPLE_DEPTH];

   drum_sample_trigger_mixer_unit #(
      .TRACKS       (TRACKS),
      .SAMPLE_DEPTH (SAMPLE_DEPTH)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_buttons    (req_buttons),
      .req_load_track (req_load_track),
      .req_load_index (req_load_index),
      .req_load_value (req_load_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_dac_value  (rsp_dac_value)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // --------------------------------------------------------------------------
   // Checking helpers
   // --------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [DAC_W-1:0] got,
                                  input logic [DAC_W-1:0] want);
      $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
      error_count++;
   endtask

   // a length above the memory depth plays as the full depth
   function automatic int eff_length(input int t);
      if (track_len[t] > SAMPLE_DEPTH)
         return SAMPLE_DEPTH;
      return track_len[t];
   endfunction

   function automatic logic [CSR_IDX_W-1:0] length_reg(input int t);
      return REG_LENGTH_TRACK0 + CSR_IDX_W'(t);
   endfunction

   // one audio tick: debounce every button, then sum the playing tracks
   task automatic mix_tick(input logic [BUTTON_BITS-1:0] buttons,
                           output logic [DAC_W-1:0] dac);
      int t;
      int n;
      int pos;
      int addr;
      int sum;
      sum = 0;
      for (t = 0; t < TRACKS; t++) begin
         // active low; tracks past the button field read as released
         if (t < BUTTON_BITS && !buttons[t]) begin
            if (hold_cnt[t] == thresh) begin
               n = eff_length(t);
               // zero length starts nothing, a playing track keeps on
               if (n != 0) begin
                  remain[t] = n;
                  active[t] = 1'b1;
               end
            end
            if (hold_cnt[t] != HOLD_MAX)
               hold_cnt[t]++;
         end else begin
            hold_cnt[t] = '0;
         end
      end
      for (t = 0; t < TRACKS; t++) begin
         if (active[t]) begin
            if (remain[t] == 0) begin
               active[t] = 1'b0;
            end else begin
               n = eff_length(t);
               // length shrunk under a playing track: stay on sample zero
               pos = (remain[t] <= n) ? n - remain[t] : 0;
               if (pos >= SAMPLE_DEPTH)
                  pos = 0;
               addr = t * SAMPLE_DEPTH + pos;
               if (!sample_seen[addr])
                  report_mismatch("stimulus read an unwritten sample", '0, '0);
               sum += $signed(sample_mem[addr]);
               remain[t]--;
               if (remain[t] == 0)
                  active[t] = 1'b0;
            end
         end
      end
      if (sum < MIX_MIN)
         sum = MIX_MIN;
      else if (sum > MIX_MAX)
         sum = MIX_MAX;
      dac = DAC_W'(sum + DAC_OFFSET);
   endtask

   // --------------------------------------------------------------------------
   // Monitor: track config, predict each accepted request, check responses.
   // Sampled at the rising edge, stimulus moves on the falling edge.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      logic [DAC_W-1:0] predicted;
      logic [DAC_W-1:0] want;
      int               addr;
      bit               taken;
      taken = 1'b0;
      if (reset) begin
         thresh = STABLE_RESET;
         for (int t = 0; t < TRACKS; t++) begin
            track_len[t] = '0;
            hold_cnt[t]  = '0;
            remain[t]    = 0;
            active[t]    = 1'b0;
         end
      end else begin
         if (csr_write) begin
            if (csr_index == REG_STABLE_TICKS)
               thresh = csr_data;
            else if (csr_index >= REG_LENGTH_TRACK0 &&
                     int'(csr_index - REG_LENGTH_TRACK0) < LEN_REGS)
               track_len[csr_index - REG_LENGTH_TRACK0] = csr_data[LEN_W-1:0];
            // anything past the length registers is dropped
         end
         if (req_valid && !req_stall) begin
            taken = 1'b1;
            if (req_command == CMD_LOAD) begin
               // loads past the last track are ignored
               if (req_load_track < TRACKS && req_load_index < SAMPLE_DEPTH) begin
                  addr = req_load_track * SAMPLE_DEPTH + req_load_index;
                  sample_mem[addr]  = req_load_value;
                  sample_seen[addr] = 1'b1;
               end
            end else begin
               mix_tick(req_buttons, predicted);
               dac_expect_q.push_back(typed_dac_en ? typed_dac : predicted);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            taken = 1'b1;
            if (dac_expect_q.size() == 0) begin
               report_mismatch("response with no request pending", rsp_dac_value, '0);
            end else begin
               want = dac_expect_q.pop_front();
               if (rsp_dac_value !== want)
                  report_mismatch("dac_value", rsp_dac_value, want);
            end
         end
      end
      idle_cycles = taken ? 0 : idle_cycles + 1;
   end

   // --------------------------------------------------------------------------
   // Response stall: runs of free flow, light and heavy random stall, and
   // solid stall stretches.
   // --------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset || quiet) begin
         rsp_stall = 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 64);
         end
         stall_left--;
         case (stall_mode)
            0: rsp_stall = 1'b0;
            1: rsp_stall = ($urandom_range(0, 3) == 0);
            2: rsp_stall = ($urandom_range(0, 3) != 0);
            default: rsp_stall = 1'b1;
         endcase
      end
   end

   // nothing accepted for too long: hang
   initial begin : watchdog
      while (idle_cycles < WATCHDOG_LIMIT)
         @(posedge clock);
      $display("[drum_sample_trigger_mixer_unit] ERROR");
      $finish;
   end

   // --------------------------------------------------------------------------
   // Sender. Called at a falling edge, returns at the falling edge after the
   // request was taken, with valid still high. Bursts of random length with
   // random gaps in between.
   // --------------------------------------------------------------------------
   task automatic push_request(input logic cmd, input logic [BUTTON_BITS-1:0] buttons,
                               input logic [TRK_FIELD_W-1:0] trk,
                               input logic [IDX_FIELD_W-1:0] idx,
                               input logic [SAMPLE_W-1:0] val,
                               input logic typed, input logic [DAC_W-1:0] dac);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid      = 1'b1;
      req_command    = cmd;
      req_buttons    = buttons;
      req_load_track = trk;
      req_load_index = idx;
      req_load_value = val;
      typed_dac_en   = typed;
      typed_dac      = dac;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_tick(input logic [BUTTON_BITS-1:0] buttons);
      push_request(CMD_TICK, buttons, TRK_FIELD_W'($urandom), IDX_FIELD_W'($urandom),
                   SAMPLE_W'($urandom), 1'b0, '0);
   endtask

   task automatic send_load(input logic [TRK_FIELD_W-1:0] trk,
                            input logic [IDX_FIELD_W-1:0] idx,
                            input logic [SAMPLE_W-1:0] val);
      push_request(CMD_LOAD, BUTTON_BITS'($urandom), trk, idx, val, 1'b0, '0);
   endtask

   // hold off until every pending tick has its response
   task automatic drain_results();
      req_valid = 1'b0;
      while (dac_expect_q.size() != 0)
         @(negedge clock);
   endtask

   // block fully idle, loads included, before a register write
   task automatic settle();
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = data;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   function automatic void add_row(input row_kind_type kind,
                                   input logic [BUTTON_BITS-1:0] buttons,
                                   input logic [CSR_IDX_W-1:0] sel,
                                   input logic [IDX_FIELD_W-1:0] index,
                                   input logic [SAMPLE_W-1:0] value,
                                   input logic typed, input logic [DAC_W-1:0] dac);
      script_row_type row;
      row.kind    = kind;
      row.buttons = buttons;
      row.sel     = sel;
      row.index   = index;
      row.value   = value;
      row.typed   = typed;
      row.dac     = dac;
      script_q.push_back(row);
   endfunction

   // --------------------------------------------------------------------------
   // Stimulus
   // --------------------------------------------------------------------------
   initial begin : stimulus
      script_row_type         row;
      int                     thresh_pick;
      int                     len_pick;
      int                     done;
      int                     hold_left;
      logic [BUTTON_BITS-1:0] held;
      logic [BUTTON_BITS-1:0] btn;
      logic [TRK_FIELD_W-1:0] trk;
      logic [IDX_FIELD_W-1:0] idx;
      logic [SAMPLE_W-1:0]    val;

      repeat (6) @(negedge clock);
      reset = 1'b0;

      // every sample a track can reach stays inside this written prefix
      for (int t = 0; t < TRACKS; t++)
         for (int i = 0; i < PRELOAD_DEPTH; i++)
            send_load(TRK_FIELD_W'(t), IDX_FIELD_W'(i), SAMPLE_W'($urandom));

      // reset values: lengths zero, nothing plays
      add_row(ROW_TICK, ALL_RELEASED, '0, '0, '0, 1'b1, DAC_MID);
      add_row(ROW_TICK, ALL_PRESSED,  '0, '0, '0, 1'b1, DAC_MID);
      // full-scale positive sample on every track, one junk load past the end
      for (int t = 0; t < TRACKS; t++)
         add_row(ROW_LOAD, '0, CSR_IDX_W'(t), '0, SAMPLE_MAX, 1'b0, '0);
      add_row(ROW_LOAD, '0, 3'd7, '0, SAMPLE_MIN, 1'b0, '0);
      add_row(ROW_LOAD, '0, 3'd2, 14'h3FFF, 16'h1234, 1'b0, '0);
      add_row(ROW_REG, '0, REG_STABLE_TICKS, '0, 16'd0, 1'b0, '0);
      for (int t = 0; t < TRACKS; t++)
         add_row(ROW_REG, '0, length_reg(t), '0, 16'd1, 1'b0, '0);
      // positive clip
      add_row(ROW_TICK, ALL_RELEASED, '0, '0, '0, 1'b1, DAC_MID);
      add_row(ROW_TICK, ALL_PRESSED,  '0, '0, '0, 1'b1, DAC_TOP);
      // negative clip
      for (int t = 0; t < TRACKS; t++)
         add_row(ROW_LOAD, '0, CSR_IDX_W'(t), '0, SAMPLE_MIN, 1'b0, '0);
      add_row(ROW_TICK, ALL_RELEASED, '0, '0, '0, 1'b1, DAC_MID);
      add_row(ROW_TICK, ALL_PRESSED,  '0, '0, '0, 1'b1, DAC_BOTTOM);
      // track 0 disabled, track 1 past the depth, track 2 at full depth
      // (never pressed while that long)
      add_row(ROW_REG, '0, length_reg(0), '0, 16'd0, 1'b0, '0);
      add_row(ROW_REG, '0, length_reg(1), '0, 16'hFFFF, 1'b0, '0);
      add_row(ROW_REG, '0, length_reg(2), '0, 16'd16384, 1'b0, '0);
      add_row(ROW_TICK, ALL_RELEASED, '0, '0, '0, 1'b0, '0);
      add_row(ROW_TICK, 6'b111100,    '0, '0, '0, 1'b0, '0);
      add_row(ROW_TICK, ALL_RELEASED, '0, '0, '0, 1'b0, '0);
      add_row(ROW_TICK, ALL_RELEASED, '0, '0, '0, 1'b0, '0);
      // shrink under the playing track, then a write outside the map
      add_row(ROW_REG, '0, length_reg(1), '0, 16'd5, 1'b0, '0);
      add_row(ROW_TICK, ALL_RELEASED, '0, '0, '0, 1'b0, '0);
      add_row(ROW_REG, '0, REG_OUT_OF_LIST, '0, 16'hFFFF, 1'b0, '0);
      add_row(ROW_TICK, 6'b111101,    '0, '0, '0, 1'b0, '0);
      // zero length while playing: no restart, playback goes on
      add_row(ROW_REG, '0, length_reg(1), '0, 16'd0, 1'b0, '0);
      add_row(ROW_TICK, 6'b111101,    '0, '0, '0, 1'b0, '0);
      add_row(ROW_REG, '0, length_reg(2), '0, 16'd0, 1'b0, '0);

      foreach (script_q[k]) begin
         row = script_q[k];
         case (row.kind)
            ROW_REG: begin
               settle();
               write_reg(row.sel, row.value);
            end
            ROW_LOAD: send_load(row.sel, row.index, row.value);
            default: push_request(CMD_TICK, row.buttons, TRK_FIELD_W'($urandom),
                                  IDX_FIELD_W'($urandom), SAMPLE_W'($urandom),
                                  row.typed, row.dac);
         endcase
      end

      // random phases, each with a fresh threshold and set of lengths
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         if (p == 0)
            thresh_pick = 0;
         else if (p == RANDOM_PHASES - 1)
            thresh_pick = 65534;
         else if ($urandom_range(0, 3) == 0)
            thresh_pick = $urandom_range(4, 12);
         else
            thresh_pick = $urandom_range(0, 3);
         write_reg(REG_STABLE_TICKS, CSR_DATA_W'(thresh_pick));
         for (int t = 0; t < TRACKS; t++) begin
            case ($urandom_range(0, 5))
               0: len_pick = 0;
               1: len_pick = 1;
               2: len_pick = PRELOAD_DEPTH;
               default: len_pick = $urandom_range(1, PRELOAD_DEPTH);
            endcase
            write_reg(length_reg(t), CSR_DATA_W'(len_pick));
         end
         if ($urandom_range(0, 3) == 0)
            write_reg(REG_OUT_OF_LIST, CSR_DATA_W'($urandom));

         done      = 0;
         hold_left = 0;
         held      = ALL_RELEASED;
         while (done < PHASE_ITEMS) begin
            if ($urandom_range(0, 49) == 0)
               drain_results();
            if ($urandom_range(0, 3) == 0) begin
               trk = TRK_FIELD_W'($urandom_range(0, 7));
               idx = $urandom_range(0, 1) ? IDX_FIELD_W'($urandom_range(0, PRELOAD_DEPTH - 1))
                                          : IDX_FIELD_W'($urandom);
               if ($urandom_range(0, 7) == 0)
                  val = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
               else
                  val = SAMPLE_W'($urandom);
               send_load(trk, idx, val);
               if (trk < TRACKS)
                  done++;
            end else begin
               // hold a pattern for a random run, which at small thresholds can cross it
               if (hold_left == 0) begin
                  case ($urandom_range(0, 3))
                     0: held = ALL_RELEASED;
                     1: held = ~(BUTTON_BITS'(1) << $urandom_range(0, BUTTON_BITS - 1));
                     default: held = BUTTON_BITS'($urandom);
                  endcase
                  hold_left = $urandom_range(1, (thresh_pick > 12) ? 20 : thresh_pick + 4);
               end
               hold_left--;
               // occasional bounce breaks the hold
               btn = ($urandom_range(0, 7) == 0) ? BUTTON_BITS'($urandom) : held;
               send_tick(btn);
               done++;
            end
         end
      end

      // threshold at its top: a short hold never reaches it, nothing starts
      settle();
      write_reg(REG_STABLE_TICKS, HOLD_MAX);
      write_reg(length_reg(0), 16'd3);
      quiet = 1'b1;
      send_tick(ALL_RELEASED);
      repeat (TOP_HOLD_TICKS) send_tick(TRACK0_PRESSED);
      quiet = 1'b0;

      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (error_count == 0)
         $display("[drum_sample_trigger_mixer_unit] OK");
      else
         $display("[drum_sample_trigger_mixer_unit] ERROR");
      $finish;
   end

endmodule

>>> filelist.f
hdl/dstm_pkg.sv
hdl/dstm_ctrl.sv
hdl/dstm_datapath.sv
hdl/drum_sample_trigger_mixer_unit.sv
tb/tb_drum_sample_trigger_mixer_unit.sv
